>>> sv/binary_trie_prefix_lookup_defines.svh
// assertion macros for the binary trie prefix lookup block
`ifndef BINARY_TRIE_PREFIX_LOOKUP_DEFINES_SVH
`define BINARY_TRIE_PREFIX_LOOKUP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BTPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BTPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/btpl_pkg.sv
// package: shared types and codes of the binary trie prefix lookup block
`timescale 1ns / 1ps
`default_nettype none

package btpl_pkg;

    localparam int ADDR_W = 128;
    localparam int LEN_W  = 8;
    localparam int HOP_W  = 8;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } walk_state_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  prefix_len;
        logic [HOP_W-1:0]  hop;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [HOP_W-1:0] hop;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } walk_ctl_t;

endpackage

`default_nettype wire

>>> sv/btpl_if.sv
// interfaces: request and response channels
`timescale 1ns / 1ps
`default_nettype none

interface btpl_req_if;
    logic         valid;
    logic         ready;
    logic         op;
    logic [63:0]  addr_high;
    logic [63:0]  addr_low;
    logic [7:0]   prefix_len;
    logic [7:0]   hop_in;

    modport source (output valid, op, addr_high, addr_low, prefix_len, hop_in,
                    input ready);
    modport sink   (input valid, op, addr_high, addr_low, prefix_len, hop_in,
                    output ready);
endinterface

interface btpl_rsp_if;
    logic         valid;
    logic         ready;
    logic [1:0]   status;
    logic [7:0]   hop_out;

    modport source (output valid, status, hop_out, input ready);
    modport sink   (input valid, status, hop_out, output ready);
endinterface

`default_nettype wire

>>> sv/btpl_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module btpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/btpl_walk.sv
// trie walk engine: one trie level per cycle, address bits shifted out msb first
`timescale 1ns / 1ps
`default_nettype none

module btpl_walk
    import btpl_pkg::*;
#(
    parameter int NODE_COUNT = 4096,
    parameter int ADDR_BITS  = 128
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire req_t      req,
    input  wire logic      take,
    output walk_ctl_t      ctl,
    output res_t           res
);

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int FREE_W  = $clog2(NODE_COUNT + 1);
    localparam int DEPTH_W = $clog2(ADDR_BITS + 1);
    localparam int NODE_W  = 1 + HOP_W + 2 * IDX_W;

    walk_state_t          state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [DEPTH_W-1:0]   len_reg, len_next;
    logic [HOP_W-1:0]     hop_in_reg, hop_in_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    logic                 cur_root_reg, cur_root_next;
    logic                 cur_fresh_reg, cur_fresh_next;
    logic                 found_reg, found_next;
    logic [HOP_W-1:0]     hop_reg, hop_next;
    status_t              status_reg, status_next;
    logic                 root_valid_reg, root_valid_next;
    logic [HOP_W-1:0]     root_hop_reg, root_hop_next;
    logic [IDX_W-1:0]     root_left_reg, root_left_next;
    logic [IDX_W-1:0]     root_right_reg, root_right_next;
    logic [FREE_W-1:0]    free_reg, free_next;

    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [NODE_W-1:0]    mem_wr_data;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [NODE_W-1:0]    mem_rd_data;

    logic                 cur_valid;
    logic [HOP_W-1:0]     cur_hop;
    logic [IDX_W-1:0]     cur_left;
    logic [IDX_W-1:0]     cur_right;
    logic                 dir_bit;
    logic [IDX_W-1:0]     child;
    logic [IDX_W-1:0]     new_idx;
    logic [ADDR_BITS-1:0] addr_shifted;

    btpl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // current node: root flops, a freshly allocated (empty) node, or memory
    always_comb
    begin
        priority if (cur_root_reg)
        begin
            cur_valid = root_valid_reg;
            cur_hop   = root_hop_reg;
            cur_left  = root_left_reg;
            cur_right = root_right_reg;
        end
        else if (cur_fresh_reg)
        begin
            cur_valid = 1'b0;
            cur_hop   = '0;
            cur_left  = '0;
            cur_right = '0;
        end
        else
        begin
            cur_valid = mem_rd_data[NODE_W-1];
            cur_hop   = mem_rd_data[NODE_W-2 -: HOP_W];
            cur_left  = mem_rd_data[2*IDX_W-1 -: IDX_W];
            cur_right = mem_rd_data[IDX_W-1:0];
        end
    end

    assign dir_bit      = addr_reg[ADDR_BITS-1];
    assign child        = dir_bit ? cur_right : cur_left;
    assign new_idx      = free_reg[IDX_W-1:0];
    assign addr_shifted = {addr_reg[ADDR_BITS-2:0], 1'b0};

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        hop_in_next     = hop_in_reg;
        depth_next      = depth_reg;
        cur_idx_next    = cur_idx_reg;
        cur_root_next   = cur_root_reg;
        cur_fresh_next  = cur_fresh_reg;
        found_next      = found_reg;
        hop_next        = hop_reg;
        status_next     = status_reg;
        root_valid_next = root_valid_reg;
        root_hop_next   = root_hop_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        free_next       = free_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cur_idx_reg;
        mem_wr_data     = {cur_valid, cur_hop, cur_left, cur_right};
        mem_rd_en       = 1'b0;
        mem_rd_addr     = child;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next     = S_WALK;
                    op_next        = req.op;
                    addr_next      = req.addr[ADDR_W-1 -: ADDR_BITS];
                    hop_in_next    = req.hop;
                    depth_next     = '0;
                    cur_idx_next   = '0;
                    cur_root_next  = 1'b1;
                    cur_fresh_next = 1'b0;
                    found_next     = 1'b0;
                    hop_next       = '0;
                    // long prefixes saturate to the address width
                    if ({1'b0, req.prefix_len} > (LEN_W + 1)'(ADDR_BITS))
                    begin
                        len_next = DEPTH_W'(ADDR_BITS);
                    end
                    else
                    begin
                        len_next = DEPTH_W'(req.prefix_len);
                    end
                end
            end

            S_WALK:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    if (cur_valid)
                    begin
                        found_next = 1'b1;
                        hop_next   = cur_hop;
                    end
                    if (depth_reg == DEPTH_W'(ADDR_BITS) || child == '0)
                    begin
                        state_next  = S_DONE;
                        status_next = (cur_valid || found_reg) ? ST_OK : ST_NOMATCH;
                    end
                    else
                    begin
                        mem_rd_en      = 1'b1;
                        cur_idx_next   = child;
                        cur_root_next  = 1'b0;
                        cur_fresh_next = 1'b0;
                        depth_next     = depth_reg + 1'b1;
                        addr_next      = addr_shifted;
                    end
                end
                else
                begin
                    hop_next = '0;
                    priority if (depth_reg == len_reg)
                    begin
                        // final node: set hop if empty; a zero-length prefix always overwrites
                        state_next  = S_DONE;
                        status_next = ST_OK;
                        if (!cur_valid || len_reg == '0)
                        begin
                            if (cur_root_reg)
                            begin
                                root_valid_next = 1'b1;
                                root_hop_next   = hop_in_reg;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = {1'b1, hop_in_reg, cur_left, cur_right};
                            end
                        end
                    end
                    else if (child != '0)
                    begin
                        mem_rd_en      = 1'b1;
                        cur_idx_next   = child;
                        cur_root_next  = 1'b0;
                        cur_fresh_next = 1'b0;
                        depth_next     = depth_reg + 1'b1;
                        addr_next      = addr_shifted;
                    end
                    else if (free_reg == FREE_W'(NODE_COUNT))
                    begin
                        // pool exhausted: a fresh node still gets its empty contents
                        state_next  = S_DONE;
                        status_next = ST_FULL;
                        mem_wr_en   = cur_fresh_reg;
                        mem_wr_data = '0;
                    end
                    else
                    begin
                        // allocate: link the new node into the current one
                        if (cur_root_reg)
                        begin
                            if (dir_bit)
                            begin
                                root_right_next = new_idx;
                            end
                            else
                            begin
                                root_left_next = new_idx;
                            end
                        end
                        else
                        begin
                            mem_wr_en = 1'b1;
                            if (dir_bit)
                            begin
                                mem_wr_data = {cur_valid, cur_hop, cur_left, new_idx};
                            end
                            else
                            begin
                                mem_wr_data = {cur_valid, cur_hop, new_idx, cur_right};
                            end
                        end
                        free_next      = free_reg + 1'b1;
                        cur_idx_next   = new_idx;
                        cur_root_next  = 1'b0;
                        cur_fresh_next = 1'b1;
                        depth_next     = depth_reg + 1'b1;
                        addr_next      = addr_shifted;
                    end
                end
            end

            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_valid_reg <= 1'b0;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            free_reg       <= FREE_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            root_valid_reg <= root_valid_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            free_reg       <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        len_reg       <= len_next;
        hop_in_reg    <= hop_in_next;
        depth_reg     <= depth_next;
        cur_idx_reg   <= cur_idx_next;
        cur_root_reg  <= cur_root_next;
        cur_fresh_reg <= cur_fresh_next;
        found_reg     <= found_next;
        hop_reg       <= hop_next;
        status_reg    <= status_next;
        root_hop_reg  <= root_hop_next;
    end

    assign ctl.idle   = (state_reg == S_IDLE);
    assign ctl.done   = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.hop    = hop_reg;

endmodule

`default_nettype wire

>>> sv/binary_trie_prefix_lookup.sv
// top level: ipv6 binary trie longest prefix match with insert
//
// one request transaction is either a lookup (op 0) or a prefix insert (op 1),
// and every request yields exactly one response transaction. the trie lives in a
// node memory of NODE_COUNT entries; the root node is kept in flip-flops and is
// empty after reset, so no clearing pass is needed. the walk handles one trie
// level per cycle: the address is shifted out one bit per cycle msb first, and
// the child pointer taken from the registered memory read addresses the next
// read directly. a request occupies the engine through its walk and its result
// state, and a new request is taken only once the engine is back in idle. a
// walk descends at most ADDR_BITS levels; the single node memory read per
// level limits the walk. lookups return status 0 with the hop of the deepest
// matching prefix, or status 1 and hop 0. inserts return status 0, or status 2
// when the node pool runs out (nodes already linked stay in the trie without a
// hop). an insert onto a node that already carries a hop leaves it unchanged,
// except a zero-length prefix, which always overwrites the root. prefix lengths
// above ADDR_BITS saturate. the response sits in an output register, so a
// finished result waiting on the consumer does not stop the engine walking
// the next request, whose result then waits in the done state until drained.
`timescale 1ns / 1ps
`default_nettype none

`include "binary_trie_prefix_lookup_defines.svh"

module binary_trie_prefix_lookup
    import btpl_pkg::*;
#(
    parameter int NODE_COUNT = 4096,
    parameter int ADDR_BITS  = 128
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    btpl_req_if.sink    req,
    btpl_rsp_if.source  rsp
);

    req_t             walk_req;
    res_t             walk_res;
    walk_ctl_t        walk_ctl;
    logic             start;
    logic             take;

    logic             rsp_valid_reg, rsp_valid_next;
    status_t          rsp_status_reg, rsp_status_next;
    logic [HOP_W-1:0] rsp_hop_reg, rsp_hop_next;

    // request side: accept only when the engine is free
    assign req.ready           = walk_ctl.idle;
    assign start               = req.valid && walk_ctl.idle;
    assign walk_req.op         = op_t'(req.op);
    assign walk_req.addr       = {req.addr_high, req.addr_low};
    assign walk_req.prefix_len = req.prefix_len;
    assign walk_req.hop        = req.hop_in;

    btpl_walk #(
        .NODE_COUNT (NODE_COUNT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (walk_req),
        .take  (take),
        .ctl   (walk_ctl),
        .res   (walk_res)
    );

    // response register: load when empty or being drained this cycle
    assign take = walk_ctl.done && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_hop_next    = rsp_hop_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (take)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = walk_res.status;
            rsp_hop_next    = walk_res.hop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_hop_reg    <= rsp_hop_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.hop_out = rsp_hop_reg;

    // an accepted transaction keeps the engine busy in the next cycle
    `BTPL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready,
        !walk_ctl.idle, "engine idle right after accepting a request")

    // only a status-ok response can carry a nonzero hop
    `BTPL_ASSERT_NOW(a_hop_zero_unless_ok, clk, rst_n,
        rsp_valid_reg && rsp_status_reg != ST_OK, rsp_hop_reg == '0,
        "nonzero hop on a response without a match")

    // a new response only follows a finished walk
    `BTPL_ASSERT_NOW(a_rsp_from_walk, clk, rst_n, $rose(rsp_valid_reg),
        $past(walk_ctl.done), "response raised without a finished walk")

endmodule

`default_nettype wire
